// File: sv/merp_pkg.sv
// Shared types and constants for the MIPS relocation patcher.
package merp_pkg;

    localparam int PendingDepth = 16;
    localparam int PendIdxW     = $clog2(PendingDepth);
    localparam int PendCntW     = $clog2(PendingDepth + 1);

    localparam logic [7:0] TY_NONE  = 8'd0;
    localparam logic [7:0] TY_16    = 8'd1;
    localparam logic [7:0] TY_32    = 8'd2;
    localparam logic [7:0] TY_REL32 = 8'd3;
    localparam logic [7:0] TY_26    = 8'd4;
    localparam logic [7:0] TY_HI16  = 8'd5;
    localparam logic [7:0] TY_LO16  = 8'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PLACE = 2'd1;
    localparam logic [1:0] ST_TYPE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] CFG_DELTA = 2'd0;
    localparam logic [1:0] CFG_BASE  = 2'd1;
    localparam logic [1:0] CFG_RELOC = 2'd2;
    localparam logic [1:0] CFG_LIMIT = 2'd3;

    // Command classes handed from front to back.
    typedef enum logic [2:0] {
        CMD_PLAIN = 3'd0,  // single result, data precomputed
        CMD_HI16  = 3'd1,
        CMD_LO16  = 3'd2
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic        we;
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  status;
        logic [31:0] word;
        logic [31:0] sv;
        logic [23:0] sidx;
    } t_job;

    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  status;
        logic        last;
    } t_res;

    function automatic logic [31:0] sext16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

endpackage

// File: sv/mips_elf_relocation_patcher.sv
// MIPS ELF32 relocation patcher top level.
// From accept to result an entry passes two front stages, the queue and the back end result register.
// Throughput: one entry per cycle for most types while results are popped.
// A LO16 holds the back end: S_READ and S_TEST per pending entry, then S_LAST for its last result.
// Reset is synchronous, active low: clears control state, empties the store, loads register defaults.
module mips_elf_relocation_patcher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [32:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_reloc_type,
    input  logic [23:0]        i_symbol_index,
    input  logic               i_symbol_in_table,
    input  logic [31:0]        i_symbol_raw_value,
    input  logic               i_symbol_defined,
    input  logic [31:0]        i_entry_offset,
    input  logic [31:0]        i_section_base,
    input  logic [31:0]        i_current_word,
    input  logic               i_has_addend,
    input  logic signed [31:0] i_explicit_addend,
    output logic               empty,
    input  logic               pop,
    output logic               o_write_enable,
    output logic [31:0]        o_write_address,
    output logic [31:0]        o_write_data,
    output logic [1:0]         o_status,
    output logic               o_last
);
    logic           f_valid, q_ready, q_valid, b_take, r_valid;
    merp_pkg::t_job f_job, q_job;
    merp_pkg::t_res res;

    merp_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push(push), .o_full(full),
        .i_reloc_type, .i_symbol_index, .i_symbol_in_table, .i_symbol_raw_value,
        .i_symbol_defined, .i_entry_offset, .i_section_base, .i_current_word,
        .i_has_addend, .i_explicit_addend,
        .o_job_valid(f_valid), .o_job(f_job), .i_job_ready(q_ready)
    );

    merp_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(f_valid), .o_ready(q_ready), .i_job(f_job),
        .o_valid(q_valid), .o_job(q_job), .i_rd(b_take)
    );

    merp_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .i_job(q_job), .o_job_take(b_take),
        .o_res_valid(r_valid), .o_res(res), .i_res_take(pop)
    );

    assign empty           = !r_valid;
    assign o_write_enable  = res.we;
    assign o_write_address = res.addr;
    assign o_write_data    = res.data;
    assign o_status        = res.status;
    assign o_last          = res.last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while stalled");
    a_nowrite_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != merp_pkg::ST_OK) |-> (!o_write_enable && o_last))
        else $error("error result carries a write");
    a_flush_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> o_write_enable)
        else $error("flushed result without write");
endmodule

// File: sv/merp_front.sv
// Front end: resolves symbol and place, classifies the entry into a job.
module merp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [32:0]        i_cfg_data,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_reloc_type,
    input  logic [23:0]        i_symbol_index,
    input  logic               i_symbol_in_table,
    input  logic [31:0]        i_symbol_raw_value,
    input  logic               i_symbol_defined,
    input  logic [31:0]        i_entry_offset,
    input  logic [31:0]        i_section_base,
    input  logic [31:0]        i_current_word,
    input  logic               i_has_addend,
    input  logic signed [31:0] i_explicit_addend,
    output logic               o_job_valid,
    output merp_pkg::t_job     o_job,
    input  logic               i_job_ready
);
    logic [31:0] r_delta, r_base, r_limit;
    logic        r_reloc;

    // stage 1 registers
    logic        r_v1;
    logic [7:0]  r_type;
    logic [23:0] r_sidx;
    logic [31:0] r_sv, r_word, r_addend;
    logic [32:0] r_place;
    // stage 2 output register
    logic           r_v2;
    merp_pkg::t_job r_job;

    logic [31:0] n_sv;
    logic        adv2, adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
            r_base  <= '0;
            r_reloc <= 1'b0;
            r_limit <= 32'd2097152;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                merp_pkg::CFG_DELTA: r_delta <= i_cfg_data[31:0];
                merp_pkg::CFG_BASE:  r_base  <= i_cfg_data[31:0];
                merp_pkg::CFG_RELOC: r_reloc <= i_cfg_data[0];
                merp_pkg::CFG_LIMIT: r_limit <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_sv = r_reloc ? r_base : 32'd0;
        if (i_symbol_in_table && (!r_reloc || i_symbol_index != 24'd0))
            n_sv = i_symbol_raw_value + (i_symbol_defined ? r_delta : 32'd0);
    end

    assign adv2   = !r_v2 || i_job_ready;
    assign adv1   = !r_v1 || adv2;
    assign o_full = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_push;
        end
        if (adv1 && i_push) begin
            r_type   <= i_reloc_type;
            r_sidx   <= i_symbol_index;
            r_sv     <= n_sv;
            r_word   <= i_current_word;
            r_addend <= i_has_addend ? i_explicit_addend : i_current_word;
            r_place  <= {1'b0, (r_reloc ? r_base : i_section_base)} + {1'b0, i_entry_offset};
        end
    end

    merp_pkg::t_job n_job;
    logic [33:0]    place3;
    logic [31:0]    tgt;

    always_comb begin
        place3       = {1'b0, r_place} + 34'd3;
        tgt          = {r_word[25:0], 2'b00} + r_sv;
        n_job.cmd    = merp_pkg::CMD_PLAIN;
        n_job.we     = 1'b0;
        n_job.addr   = r_place[31:0];
        n_job.data   = '0;
        n_job.status = merp_pkg::ST_OK;
        n_job.word   = r_word;
        n_job.sv     = r_sv;
        n_job.sidx   = r_sidx;
        if (r_place[32] || place3 >= {2'b00, r_limit}) begin
            n_job.status = merp_pkg::ST_PLACE;
        end else begin
            case (r_type)
                merp_pkg::TY_NONE: ;
                merp_pkg::TY_32, merp_pkg::TY_REL32: begin
                    n_job.we   = 1'b1;
                    n_job.data = r_addend + r_sv;
                end
                merp_pkg::TY_26: begin
                    n_job.we   = 1'b1;
                    n_job.data = {r_word[31:26], tgt[27:2]};
                end
                merp_pkg::TY_16: begin
                    n_job.we   = 1'b1;
                    n_job.data = {r_word[31:16], r_addend[15:0] + r_sv[15:0]};
                end
                merp_pkg::TY_HI16: n_job.cmd = merp_pkg::CMD_HI16;
                merp_pkg::TY_LO16: n_job.cmd = merp_pkg::CMD_LO16;
                default: n_job.status = merp_pkg::ST_TYPE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
        if (adv2 && r_v1) r_job <= n_job;
    end

    assign o_job_valid = r_v2;
    assign o_job       = r_job;
endmodule

// File: sv/merp_queue.sv
// Two-entry job queue between front and back.
module merp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    output logic           o_ready,
    input  merp_pkg::t_job i_job,
    output logic           o_valid,
    output merp_pkg::t_job o_job,
    input  logic           i_rd
);
    merp_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr      = i_wr && o_ready;
    assign rd      = i_rd && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) r_mem[r_wp] <= i_job;
    end
endmodule

// File: sv/merp_back.sv
// Back end: pending HI16 store, LO16 flush walk and result register.
module merp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  merp_pkg::t_job i_job,
    output logic           o_job_take,
    output logic           o_res_valid,
    output merp_pkg::t_res o_res,
    input  logic           i_res_take
);
    localparam int D  = merp_pkg::PendingDepth;
    localparam int IW = merp_pkg::PendIdxW;
    localparam int CW = merp_pkg::PendCntW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_TEST = 4'b0100,
        S_LAST = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // compacted store: slots 0..r_cnt-1 hold entries in arrival order
    logic [31:0] r_paddr [D];
    logic [31:0] r_phi   [D];
    logic [31:0] r_psv   [D];
    logic [23:0] r_psidx [D];
    logic [CW-1:0] r_cnt;

    logic [CW-1:0] r_rd;  // read position in old store
    logic [CW-1:0] r_wr;  // write position for kept entries
    merp_pkg::t_job r_cur;
    logic [31:0] r_ea, r_eh, r_es;
    logic [23:0] r_ei;

    logic           r_ov;
    merp_pkg::t_res r_res;
    logic           out_free;
    logic           res_load;

    logic [31:0] full_v, lo;

    assign out_free    = !r_ov || i_res_take;
    assign o_res_valid = r_ov;
    assign o_res       = r_res;
    assign o_job_take  = (r_state == S_IDLE) && i_job_valid && out_free;
    assign lo          = merp_pkg::sext16(r_cur.word);
    assign full_v      = {r_eh[15:0], 16'h0000} + lo + r_es;
    assign res_load    = (o_job_take && i_job.cmd != merp_pkg::CMD_LO16)
                      || (r_state == S_TEST && r_ei == r_cur.sidx && out_free)
                      || (r_state == S_LAST && out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_job_take && i_job.cmd == merp_pkg::CMD_LO16)
                        n_state = (r_cnt != '0) ? S_READ : S_LAST;
            S_READ: n_state = S_TEST;
            S_TEST: if (r_ei != r_cur.sidx || out_free)
                        n_state = (r_rd == r_cnt) ? S_LAST : S_READ;
            S_LAST: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= res_load || (r_ov && !i_res_take);
            case (r_state)
                S_IDLE: if (o_job_take) begin
                    r_cur <= i_job;
                    r_rd  <= '0;
                    r_wr  <= '0;
                    if (i_job.cmd != merp_pkg::CMD_LO16) begin
                        r_res.we     <= i_job.we;
                        r_res.addr   <= i_job.addr;
                        r_res.data   <= i_job.data;
                        r_res.last   <= 1'b1;
                        if (i_job.cmd == merp_pkg::CMD_HI16 && r_cnt == CW'(D)) begin
                            r_res.status <= merp_pkg::ST_FULL;
                        end else begin
                            r_res.status <= i_job.status;
                        end
                        if (i_job.cmd == merp_pkg::CMD_HI16 && r_cnt != CW'(D)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_READ: begin
                    r_ea <= r_paddr[r_rd[IW-1:0]];
                    r_eh <= r_phi[r_rd[IW-1:0]];
                    r_es <= r_psv[r_rd[IW-1:0]];
                    r_ei <= r_psidx[r_rd[IW-1:0]];
                    r_rd <= r_rd + 1'b1;
                end
                S_TEST: begin
                    if (r_ei != r_cur.sidx) begin
                        r_wr <= r_wr + 1'b1;
                        if (r_rd == r_cnt) r_cnt <= r_wr + 1'b1;
                    end else if (out_free) begin
                        r_res.we     <= 1'b1;
                        r_res.addr   <= r_ea;
                        r_res.data   <= {r_eh[31:16], 16'((full_v + 32'h8000) >> 16)};
                        r_res.status <= merp_pkg::ST_OK;
                        r_res.last   <= 1'b0;
                        if (r_rd == r_cnt) r_cnt <= r_wr;
                    end
                end
                S_LAST: if (out_free) begin
                    r_res.we     <= 1'b1;
                    r_res.addr   <= r_cur.addr;
                    r_res.data   <= {r_cur.word[31:16], lo[15:0] + r_cur.sv[15:0]};
                    r_res.status <= merp_pkg::ST_OK;
                    r_res.last   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // store writes: HI16 append, compaction of kept entries during a walk
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_job_take && i_job.cmd == merp_pkg::CMD_HI16
            && r_cnt != CW'(D)) begin
            r_paddr[r_cnt[IW-1:0]] <= i_job.addr;
            r_phi[r_cnt[IW-1:0]]   <= i_job.word;
            r_psv[r_cnt[IW-1:0]]   <= i_job.sv;
            r_psidx[r_cnt[IW-1:0]] <= i_job.sidx;
        end else if (r_state == S_TEST && r_ei != r_cur.sidx) begin
            r_paddr[r_wr[IW-1:0]] <= r_ea;
            r_phi[r_wr[IW-1:0]]   <= r_eh;
            r_psv[r_wr[IW-1:0]]   <= r_es;
            r_psidx[r_wr[IW-1:0]] <= r_ei;
        end
    end
endmodule

// File: test/tb_mips_elf_relocation_patcher.sv
// Self-checking testbench for the MIPS relocation patcher: random and directed entries.
module tb_mips_elf_relocation_patcher;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  rtype;
        logic [23:0] sidx;
        logic        in_tab;
        logic [31:0] raw;
        logic        defd;
        logic [31:0] eoff;
        logic [31:0] sbase;
        logic [31:0] word;
        logic        has_add;
        logic [31:0] eadd;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = merp_pkg::CFG_DELTA;
    logic [32:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_reloc_type = '0;
    logic [23:0] i_symbol_index = '0;
    logic        i_symbol_in_table = 1'b0;
    logic [31:0] i_symbol_raw_value = '0;
    logic        i_symbol_defined = 1'b0;
    logic [31:0] i_entry_offset = '0;
    logic [31:0] i_section_base = '0;
    logic [31:0] i_current_word = '0;
    logic        i_has_addend = 1'b0;
    logic signed [31:0] i_explicit_addend = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_write_enable;
    logic [31:0] o_write_address;
    logic [31:0] o_write_data;
    logic [1:0]  o_status;
    logic        o_last;

    mips_elf_relocation_patcher dut (.*);

    // predictor state
    logic [31:0] delta_q, base_q, limit_q;
    logic        reloc_q;
    logic [31:0] hi_addr[$], hi_word[$], hi_sv[$];
    logic [23:0] hi_sidx[$];

    merp_pkg::t_res expected_writes[$];
    int   error_count = 0;
    int   stall_pct = 30;

    initial forever #10 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void expect_res(logic we, logic [31:0] a, logic [31:0] d,
                                       logic [1:0] st, logic lst);
        merp_pkg::t_res r;
        r.we = we; r.addr = a; r.data = d; r.status = st; r.last = lst;
        expected_writes = {expected_writes, r};
    endfunction

    function automatic logic [31:0] sx16(logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    task automatic predict_patch(input t_entry e);
        logic [31:0] sv, place, addend, lo, hw, fullv, tgt;
        logic [32:0] place33;
        logic [33:0] chk;
        int i;
        sv = reloc_q ? base_q : 32'd0;
        if (e.in_tab && (!reloc_q || e.sidx != 0)) begin
            sv = e.raw;
            if (e.defd) sv = sv + delta_q;
        end
        place33 = {1'b0, (reloc_q ? base_q : e.sbase)} + {1'b0, e.eoff};
        place = place33[31:0];
        chk = {1'b0, place33} + 34'd3;
        if (place33[32] || chk >= {2'b0, limit_q}) begin
            expect_res(1'b0, place, 32'd0, merp_pkg::ST_PLACE, 1'b1);
            return;
        end
        addend = e.has_add ? e.eadd : e.word;
        case (e.rtype)
            merp_pkg::TY_NONE: expect_res(1'b0, place, 32'd0, merp_pkg::ST_OK, 1'b1);
            merp_pkg::TY_32, merp_pkg::TY_REL32:
                expect_res(1'b1, place, addend + sv, merp_pkg::ST_OK, 1'b1);
            merp_pkg::TY_26: begin
                tgt = {e.word[25:0], 2'b00} + sv;
                expect_res(1'b1, place, {e.word[31:26], tgt[27:2]}, merp_pkg::ST_OK, 1'b1);
            end
            merp_pkg::TY_16: begin
                tgt = addend + sv;
                expect_res(1'b1, place, {e.word[31:16], tgt[15:0]}, merp_pkg::ST_OK, 1'b1);
            end
            merp_pkg::TY_HI16: begin
                if (hi_addr.size() >= merp_pkg::PendingDepth) begin
                    expect_res(1'b0, place, 32'd0, merp_pkg::ST_FULL, 1'b1);
                end else begin
                    hi_addr = {hi_addr, place}; hi_word = {hi_word, e.word};
                    hi_sv = {hi_sv, sv}; hi_sidx = {hi_sidx, e.sidx};
                    expect_res(1'b0, place, 32'd0, merp_pkg::ST_OK, 1'b1);
                end
            end
            merp_pkg::TY_LO16: begin
                lo = sx16(e.word);
                i = 0;
                while (i < hi_addr.size()) begin
                    if (hi_sidx[i] != e.sidx) begin
                        i++;
                    end else begin
                        hw = hi_word[i];
                        fullv = (sx16(hw) << 16) + lo + hi_sv[i] + 32'h8000;
                        expect_res(1'b1, hi_addr[i], {hw[31:16], fullv[31:16]},
                                   merp_pkg::ST_OK, 1'b0);
                        hi_addr.delete(i); hi_word.delete(i);
                        hi_sv.delete(i); hi_sidx.delete(i);
                    end
                end
                tgt = lo + sv;
                expect_res(1'b1, place, {e.word[31:16], tgt[15:0]}, merp_pkg::ST_OK, 1'b1);
            end
            default: expect_res(1'b0, place, 32'd0, merp_pkg::ST_TYPE, 1'b1);
        endcase
    endtask

    task automatic send_entry(input t_entry e);
        @(negedge i_clk);
        push <= 1'b1;
        i_reloc_type <= e.rtype; i_symbol_index <= e.sidx;
        i_symbol_in_table <= e.in_tab; i_symbol_raw_value <= e.raw;
        i_symbol_defined <= e.defd; i_entry_offset <= e.eoff;
        i_section_base <= e.sbase; i_current_word <= e.word;
        i_has_addend <= e.has_add; i_explicit_addend <= e.eadd;
        do @(posedge i_clk); while (full);
        predict_patch(e);
    endtask

    // random gap between bursts, keeps push low while idle
    int burst_left = 0;
    task automatic pace;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [32:0] val);
        @(negedge i_clk);
        push <= 1'b0;
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            merp_pkg::CFG_DELTA: delta_q = val[31:0];
            merp_pkg::CFG_BASE:  base_q = val[31:0];
            merp_pkg::CFG_RELOC: reloc_q = val[0];
            default:             limit_q = val[31:0];
        endcase
    endtask

    task automatic drain;
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_writes.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_entry rand_entry(int sym_span, logic [7:0] tyhi);
        t_entry e;
        e.rtype = 8'($urandom_range(0, tyhi));
        if ($urandom_range(0, 19) == 0) e.rtype = 8'($urandom_range(0, 255));
        e.sidx = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                             : 24'($urandom_range(0, sym_span));
        e.in_tab = $urandom_range(0, 7) != 0;
        e.raw = $urandom;
        e.defd = 1'($urandom_range(0, 1));
        e.sbase = $urandom_range(0, 32'h000F_0000);
        e.eoff = {$urandom_range(0, 32'h000F_FFFF)} & ~32'h3;
        if ($urandom_range(0, 15) == 0) e.eoff = $urandom;
        e.word = $urandom;
        e.has_add = 1'($urandom_range(0, 1));
        e.eadd = $urandom;
        return e;
    endfunction

    // result checker
    initial begin
        merp_pkg::t_res x;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected result addr %h", o_write_address);
                    error_count++;
                end else begin
                    x = expected_writes.pop_front();
                    if (o_write_enable !== x.we) begin
                        $error("write_enable exp %b got %b", x.we, o_write_enable);
                        error_count++;
                    end
                    if (o_write_address !== x.addr) begin
                        $error("write_address exp %h got %h", x.addr, o_write_address);
                        error_count++;
                    end
                    if (o_write_data !== x.data) begin
                        $error("write_data exp %h got %h", x.data, o_write_data);
                        error_count++;
                    end
                    if (o_status !== x.status) begin
                        $error("status exp %0d got %0d", x.status, o_status);
                        error_count++;
                    end
                    if (o_last !== x.last) begin
                        $error("last exp %b got %b", x.last, o_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver stalls in runs
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 10);
            @(negedge i_clk);
            pop <= ($urandom_range(0, 99) >= stall_pct);
            repeat (run - 1) @(negedge i_clk);
        end
    end

    task automatic test_directed;
        t_entry e;
        logic [7:0] types[$] = '{merp_pkg::TY_NONE, merp_pkg::TY_16, merp_pkg::TY_32,
                                 merp_pkg::TY_REL32, merp_pkg::TY_26, merp_pkg::TY_HI16,
                                 8'd7, 8'hFF};
        foreach (types[k]) begin
            e = rand_entry(3, 8'd0);
            e.rtype = types[k];
            e.sbase = 32'h1000; e.eoff = 32'h40;
            e.word = (k % 2) ? 32'hFFFF_FFFF : 32'h0;
            e.eadd = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            e.sidx = (k % 2) ? 24'hFFFFFF : 24'd0;
            send_entry(e);
        end
        e = rand_entry(3, 8'd0);
        e.rtype = merp_pkg::TY_LO16; e.sidx = 24'hFFFFFF; e.sbase = 32'h200; e.eoff = 0;
        send_entry(e);
        // place past RAM and place sum overflowing 32 bits
        e.rtype = merp_pkg::TY_32; e.sbase = 32'h1F_FFFD; send_entry(e);
        e.sbase = 32'hFFFF_FFFF; e.eoff = 32'h2; send_entry(e);
        e.sbase = 32'h1F_FFFC; e.eoff = 0; send_entry(e);
        // fill the store, overflow it, then flush with one LO16
        for (int k = 0; k < merp_pkg::PendingDepth + 2; k++) begin
            e = rand_entry(0, 8'd0);
            e.rtype = merp_pkg::TY_HI16; e.sidx = 24'd5; e.sbase = 32'h100; e.eoff = 4 * k;
            send_entry(e);
        end
        e.rtype = merp_pkg::TY_LO16; send_entry(e);
        drain();
    endtask

    task automatic test_random_phase(input int count);
        for (int k = 0; k < count; k++) begin
            pace();
            send_entry(rand_entry(6, ($urandom_range(0, 1) ? merp_pkg::TY_LO16
                                                            : merp_pkg::TY_HI16)));
        end
        drain();
    endtask

    initial begin
        delta_q = 0; base_q = 0; reloc_q = 0; limit_q = 32'd2097152;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        stall_pct = 0;
        test_random_phase(50);
        write_reg(merp_pkg::CFG_DELTA, 33'h1_0000_0001);
        write_reg(merp_pkg::CFG_BASE, 33'h0_0004_0000);
        write_reg(merp_pkg::CFG_RELOC, 33'd1);
        write_reg(merp_pkg::CFG_LIMIT, 33'h0_0010_0000);
        stall_pct = 30;
        test_random_phase(70);
        write_reg(merp_pkg::CFG_DELTA, 33'h0_FFFF_FFFF);
        write_reg(merp_pkg::CFG_BASE, 33'h0_FFFF_FFF0);
        write_reg(merp_pkg::CFG_LIMIT, 33'h0_FFFF_FFFF);
        stall_pct = 60;
        test_random_phase(40);
        write_reg(merp_pkg::CFG_BASE, 33'd0);
        write_reg(merp_pkg::CFG_LIMIT, 33'd1);
        test_random_phase(15);
        write_reg(merp_pkg::CFG_RELOC, 33'd0);
        write_reg(merp_pkg::CFG_DELTA, {1'($urandom_range(0, 1)), $urandom});
        write_reg(merp_pkg::CFG_LIMIT, 33'h0_FFFF_FFFF);
        stall_pct = 20;
        test_random_phase(110);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: files.f
sv/merp_pkg.sv
sv/merp_front.sv
sv/merp_queue.sv
sv/merp_back.sv
sv/mips_elf_relocation_patcher.sv
test/tb_mips_elf_relocation_patcher.sv
